>>> rtl/bbs_pkg.sv
// Shared types, constants and helpers for the brace balance scanner.
package bbs_pkg;

    // Width of the internal saturating depth counter
    localparam int DEPTH_BITS = 16;
    // Width of the depth field on the result beat
    localparam int OUT_DEPTH_BITS = 16;
    // Sign-extended width used to clamp the counter into the result field
    localparam int CLAMP_BITS = 33;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    localparam logic signed [CLAMP_BITS-1:0] OUT_MAX =
        CLAMP_BITS'({1'b0, {(OUT_DEPTH_BITS-1){1'b1}}});
    localparam logic signed [CLAMP_BITS-1:0] OUT_MIN =
        -OUT_MAX - CLAMP_BITS'(1);

    // Character codes
    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Lexical mode codes
    typedef enum logic [2:0] {
        MODE_CODE   = 3'd0,
        MODE_BLOCK  = 3'd1,
        MODE_SQUOTE = 3'd2,
        MODE_DQUOTE = 3'd3,
        MODE_LINE   = 3'd4
    } mode_t;

    // One input beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_in_line;
        logic       start_of_action;
    } beat_t;

    // One result beat
    typedef struct packed {
        logic signed [OUT_DEPTH_BITS-1:0] brace_depth;
        mode_t                            lexical_mode;
        logic                             action_done;
    } result_t;

    // Saturate the counter into the signed result field
    function automatic logic signed [OUT_DEPTH_BITS-1:0] clamp_depth(
        input logic signed [DEPTH_BITS-1:0] d
    );
        logic signed [CLAMP_BITS-1:0] wide;
        wide = CLAMP_BITS'(d);
        if (wide > OUT_MAX) begin
            return OUT_DEPTH_BITS'(OUT_MAX);
        end else if (wide < OUT_MIN) begin
            return OUT_DEPTH_BITS'(OUT_MIN);
        end
        return wide[OUT_DEPTH_BITS-1:0];
    endfunction

endpackage

>>> rtl/bbs_core.sv
// Lexer state registers and per-beat update logic of the brace balance scanner.
module bbs_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,   // a beat moves from input to result register
    input  bbs_pkg::beat_t   beat,
    output bbs_pkg::result_t result
);

    logic signed [bbs_pkg::DEPTH_BITS-1:0] depth_reg, depth_next;
    bbs_pkg::mode_t                        mode_reg, mode_next;
    logic                                  esc_reg, esc_next;
    logic                                  slash_reg, slash_next;
    logic                                  star_reg, star_next;

    logic [7:0] c;
    logic       code_path;
    logic [7:0] closer;

    assign c = beat.char_code;

    // Next lexer state for the beat held in the input register
    always_comb begin
        // start of action clears everything before the byte
        if (beat.start_of_action) begin
            depth_next = '0;
            mode_next  = bbs_pkg::MODE_CODE;
            esc_next   = 1'b0;
            slash_next = 1'b0;
            star_next  = 1'b0;
        end else begin
            depth_next = depth_reg;
            mode_next  = mode_reg;
            esc_next   = esc_reg;
            slash_next = slash_reg;
            star_next  = star_reg;
        end
        code_path = 1'b0;
        closer    = (mode_next == bbs_pkg::MODE_SQUOTE) ? bbs_pkg::CH_SQUOTE
                                                        : bbs_pkg::CH_DQUOTE;

        case (mode_next)
            bbs_pkg::MODE_BLOCK: begin
                if (star_next && c == bbs_pkg::CH_SLASH) begin
                    mode_next = bbs_pkg::MODE_CODE;
                    star_next = 1'b0;
                end else begin
                    star_next = (c == bbs_pkg::CH_STAR);
                end
            end
            bbs_pkg::MODE_SQUOTE, bbs_pkg::MODE_DQUOTE: begin
                if (esc_next) begin
                    esc_next = 1'b0;
                end else if (c == bbs_pkg::CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (c == closer) begin
                    mode_next = bbs_pkg::MODE_CODE;
                end
            end
            bbs_pkg::MODE_LINE: begin
                // ignore until line end
            end
            default: begin
                mode_next = bbs_pkg::MODE_CODE;
                code_path = 1'b1;
                // pending slash: comment openers
                if (slash_next) begin
                    slash_next = 1'b0;
                    if (c == bbs_pkg::CH_STAR) begin
                        mode_next = bbs_pkg::MODE_BLOCK;
                        star_next = 1'b0;
                        code_path = 1'b0;
                    end else if (c == bbs_pkg::CH_SLASH) begin
                        mode_next = bbs_pkg::MODE_LINE;
                        code_path = 1'b0;
                    end
                end
            end
        endcase

        // ordinary code byte
        if (code_path) begin
            case (c)
                bbs_pkg::CH_SLASH: slash_next = 1'b1;
                bbs_pkg::CH_SQUOTE: begin
                    mode_next = bbs_pkg::MODE_SQUOTE;
                    esc_next  = 1'b0;
                end
                bbs_pkg::CH_DQUOTE: begin
                    mode_next = bbs_pkg::MODE_DQUOTE;
                    esc_next  = 1'b0;
                end
                bbs_pkg::CH_OPEN: begin
                    if (depth_next != bbs_pkg::DEPTH_MAX) begin
                        depth_next = depth_next + bbs_pkg::DEPTH_BITS'(1);
                    end
                end
                bbs_pkg::CH_CLOSE: begin
                    if (depth_next != bbs_pkg::DEPTH_MIN) begin
                        depth_next = depth_next - bbs_pkg::DEPTH_BITS'(1);
                    end
                end
                default: ;
            endcase
        end

        // line end drops the pair flags and ends a line comment
        if (beat.last_in_line) begin
            slash_next = 1'b0;
            star_next  = 1'b0;
            if (mode_next == bbs_pkg::MODE_LINE) begin
                mode_next = bbs_pkg::MODE_CODE;
            end
        end
    end

    // Result of this beat
    assign result.brace_depth  = bbs_pkg::clamp_depth(depth_next);
    assign result.lexical_mode = mode_next;
    assign result.action_done  = beat.last_in_line &&
                                 (depth_next[bbs_pkg::DEPTH_BITS-1] || depth_next == '0);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            mode_reg  <= bbs_pkg::MODE_CODE;
            esc_reg   <= 1'b0;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end else if (step_en) begin
            depth_reg <= depth_next;
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
        end
    end

endmodule

>>> rtl/brace_balance_scanner.sv
// Top level of the brace balance scanner: input register, lexer core, result register.
//
//  channel | direction | tdata (low bit up)                    | tlast        | tuser
//  s_      | in        | char_code[7:0]                        | last_in_line | start_of_action
//  m_      | out       | brace_depth[15:0], lexical_mode[18:16] | action_done  | -
//
//  One beat per cycle sustained while m_tready is high: the lexer update is one short pass between two registers.
//  m_tvalid is set when a beat moves from the input register into the result register.
//  The lexer state updates as a beat moves from the input register into the result register.
//  A stalled result register holds its beat; the input register still takes one beat behind it.
//  aresetn (synchronous, active low) empties both registers and clears depth, mode and flags.
module brace_balance_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_in_line
    input  logic        s_tuser,   // start_of_action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] brace_depth, [18:16] lexical_mode, rest zero
    output logic        m_tlast    // action_done
);

    logic              in_valid_reg;
    bbs_pkg::beat_t    in_beat_reg;
    logic              out_valid_reg;
    bbs_pkg::result_t  out_res_reg;
    bbs_pkg::result_t  core_res;
    logic              advance;

    // Beat moves forward when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_beat_reg.char_code       <= s_tdata;
            in_beat_reg.last_in_line    <= s_tlast;
            in_beat_reg.start_of_action <= s_tuser;
        end
    end

    bbs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .beat    (in_beat_reg),
        .result  (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.lexical_mode, out_res_reg.brace_depth};
    assign m_tlast  = out_res_reg.action_done;

endmodule

>>> rtl/bbs_checker.sv
// Port-level checker for the brace balance scanner and its bind.
module bbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // Stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Done only when the depth is zero or below, and never in line-comment mode
    a_done_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[15] || m_tdata[15:0] == 16'd0)
                                && m_tdata[18:16] != bbs_pkg::MODE_LINE)
        else $error("done flag with positive depth or open line comment");

    // Empty result side never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind brace_balance_scanner bbs_checker u_bbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> test/tb_brace_balance_scanner.sv
// Self-checking testbench for the brace balance scanner: directed and random beats.
module tb_brace_balance_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SEGMENT_BEATS   = 180;
    localparam logic signed [15:0] SAT_HIGH = 16'sh7FFF;
    localparam logic signed [15:0] SAT_LOW  = 16'sh8000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Characters waiting to be sent, and scan results waiting to come back
    bbs_pkg::beat_t   chars_to_send[$];
    bbs_pkg::result_t scan_results_due[$];

    // Idle odds in percent, set per phase
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    // Lexer state of the predictor
    logic signed [15:0] lex_depth  = 16'sd0;
    bbs_pkg::mode_t     lex_mode   = bbs_pkg::MODE_CODE;
    logic               lex_escape = 1'b0;
    logic               lex_slash  = 1'b0;
    logic               lex_star   = 1'b0;

    brace_balance_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Advance the lexer by one character and work out the scan result
    task automatic scan_char(input bbs_pkg::beat_t b, output bbs_pkg::result_t r);
        logic [7:0] c;
        logic [7:0] closer;
        logic       taken;
        c     = b.char_code;
        taken = 1'b0;
        if (b.start_of_action) begin
            lex_depth  = 16'sd0;
            lex_mode   = bbs_pkg::MODE_CODE;
            lex_escape = 1'b0;
            lex_slash  = 1'b0;
            lex_star   = 1'b0;
        end
        closer = (lex_mode == bbs_pkg::MODE_SQUOTE) ? bbs_pkg::CH_SQUOTE : bbs_pkg::CH_DQUOTE;
        case (lex_mode)
            bbs_pkg::MODE_BLOCK: begin
                if (lex_star && c == bbs_pkg::CH_SLASH) begin
                    lex_mode = bbs_pkg::MODE_CODE;
                    lex_star = 1'b0;
                end else begin
                    lex_star = (c == bbs_pkg::CH_STAR);
                end
            end
            bbs_pkg::MODE_SQUOTE, bbs_pkg::MODE_DQUOTE: begin
                if (lex_escape) begin
                    lex_escape = 1'b0;
                end else if (c == bbs_pkg::CH_BSLASH) begin
                    lex_escape = 1'b1;
                end else if (c == closer) begin
                    lex_mode = bbs_pkg::MODE_CODE;
                end
            end
            bbs_pkg::MODE_LINE: ;
            default: begin
                lex_mode = bbs_pkg::MODE_CODE;
                // a pending slash either opens a comment or falls away
                if (lex_slash) begin
                    lex_slash = 1'b0;
                    if (c == bbs_pkg::CH_STAR) begin
                        lex_mode = bbs_pkg::MODE_BLOCK;
                        lex_star = 1'b0;
                        taken    = 1'b1;
                    end else if (c == bbs_pkg::CH_SLASH) begin
                        lex_mode = bbs_pkg::MODE_LINE;
                        taken    = 1'b1;
                    end
                end
                if (!taken) begin
                    if (c == bbs_pkg::CH_SLASH) begin
                        lex_slash = 1'b1;
                    end else if (c == bbs_pkg::CH_SQUOTE) begin
                        lex_mode   = bbs_pkg::MODE_SQUOTE;
                        lex_escape = 1'b0;
                    end else if (c == bbs_pkg::CH_DQUOTE) begin
                        lex_mode   = bbs_pkg::MODE_DQUOTE;
                        lex_escape = 1'b0;
                    end else if (c == bbs_pkg::CH_OPEN) begin
                        if (lex_depth != SAT_HIGH) lex_depth = lex_depth + 16'sd1;
                    end else if (c == bbs_pkg::CH_CLOSE) begin
                        if (lex_depth != SAT_LOW) lex_depth = lex_depth - 16'sd1;
                    end
                end
            end
        endcase
        // comment openers and closers never span a line end; line comments stop there
        if (b.last_in_line) begin
            lex_slash = 1'b0;
            lex_star  = 1'b0;
            if (lex_mode == bbs_pkg::MODE_LINE) lex_mode = bbs_pkg::MODE_CODE;
        end
        r.brace_depth  = lex_depth;
        r.lexical_mode = lex_mode;
        r.action_done  = b.last_in_line && (lex_depth <= 0);
    endtask

    task automatic queue_beat(input logic [7:0] c, input logic eol, input logic soa);
        bbs_pkg::beat_t b;
        b.char_code       = c;
        b.last_in_line    = eol;
        b.start_of_action = soa;
        chars_to_send = {chars_to_send, b};
    endtask

    // Ordinary text character: line ends now and then, a rare fresh start
    task automatic queue_text(input logic [7:0] c);
        queue_beat(c, $urandom_range(0, 9) == 0, $urandom_range(0, 149) == 0);
    endtask

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 13))
            0:       return bbs_pkg::CH_OPEN;
            1:       return bbs_pkg::CH_CLOSE;
            2:       return bbs_pkg::CH_SLASH;
            3:       return bbs_pkg::CH_STAR;
            4:       return bbs_pkg::CH_SQUOTE;
            5:       return bbs_pkg::CH_DQUOTE;
            6:       return bbs_pkg::CH_BSLASH;
            7, 8:    return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // One lexical fragment: code, comment, literal, stray slash or noise
    task automatic queue_fragment();
        int         len;
        logic [7:0] quote;
        len = $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0, 1: begin
                repeat (len + 1) begin
                    queue_text(($urandom_range(0, 2) == 0) ? text_char() :
                               ($urandom_range(0, 1) ? bbs_pkg::CH_OPEN : bbs_pkg::CH_CLOSE));
                end
            end
            2: begin
                queue_text(bbs_pkg::CH_SLASH);
                queue_text(bbs_pkg::CH_STAR);
                repeat (len) queue_text(text_char());
                // mostly closed, sometimes left open
                if ($urandom_range(0, 7) != 0) begin
                    queue_text(bbs_pkg::CH_STAR);
                    queue_text(bbs_pkg::CH_SLASH);
                end
            end
            3: begin
                queue_text(bbs_pkg::CH_SLASH);
                queue_text(bbs_pkg::CH_SLASH);
                repeat (len) queue_beat(text_char(), 1'b0, 1'b0);
                queue_beat(text_char(), 1'b1, 1'b0);
            end
            4, 5: begin
                quote = $urandom_range(0, 1) ? bbs_pkg::CH_DQUOTE : bbs_pkg::CH_SQUOTE;
                queue_text(quote);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) queue_text(bbs_pkg::CH_BSLASH);
                    queue_text(text_char());
                end
                if ($urandom_range(0, 7) != 0) queue_text(quote);
            end
            6: begin
                queue_text(bbs_pkg::CH_SLASH);
                queue_text(text_char());
            end
            default: begin
                repeat (len + 1) begin
                    queue_beat(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1,
                               $urandom_range(0, 15) == 0);
                end
            end
        endcase
    endtask

    // Sender: predict each accepted beat, then present the next one or idle
    always @(posedge aclk) begin : char_driver
        bbs_pkg::beat_t   sent;
        bbs_pkg::result_t due;
        bbs_pkg::beat_t   next_char;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sent.char_code       = s_tdata;
                sent.last_in_line    = s_tlast;
                sent.start_of_action = s_tuser;
                scan_char(sent, due);
                scan_results_due = {scan_results_due, due};
            end
            if (!s_tvalid || s_tready) begin
                if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    next_char = chars_to_send.pop_front();
                    s_tdata  <= next_char.char_code;
                    s_tlast  <= next_char.last_in_line;
                    s_tuser  <= next_char.start_of_action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat against the oldest prediction
    always @(posedge aclk) begin : result_monitor
        bbs_pkg::result_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (scan_results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
                    end
                end else begin
                    due = scan_results_due.pop_front();
                    if (m_tdata[15:0] !== due.brace_depth || m_tdata[18:16] !== due.lexical_mode
                            || m_tlast !== due.action_done || m_tdata[23:19] !== 5'd0) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: depth %0d/%0d mode %0d/%0d done %b/%b pad %h",
                                     due.brace_depth, $signed(m_tdata[15:0]), due.lexical_mode,
                                     m_tdata[18:16], due.action_done, m_tlast, m_tdata[23:19]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    // Watchdog: too long without any beat moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("tb_brace_balance_scanner: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        // directed: comments, literals, escapes, stray slash, line-end rules
        queue_beat(bbs_pkg::CH_OPEN,   1'b0, 1'b1);
        queue_beat(bbs_pkg::CH_SLASH,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_STAR,   1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_SLASH,  1'b0, 1'b0);   // opener star does not close
        queue_beat(bbs_pkg::CH_OPEN,   1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_STAR,   1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_SLASH,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_SLASH,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_SLASH,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_CLOSE,  1'b1, 1'b0);   // line comment ends, mode back to code
        queue_beat(bbs_pkg::CH_SQUOTE, 1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_BSLASH, 1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_SQUOTE, 1'b0, 1'b0);   // escaped quote
        queue_beat(bbs_pkg::CH_SQUOTE, 1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_DQUOTE, 1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_CLOSE,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_DQUOTE, 1'b1, 1'b0);
        queue_beat(bbs_pkg::CH_SLASH,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_OPEN,   1'b0, 1'b0);   // stray slash, brace still counts
        queue_beat(bbs_pkg::CH_SLASH,  1'b1, 1'b0);
        queue_beat(bbs_pkg::CH_STAR,   1'b0, 1'b0);   // slash dropped at line end
        queue_beat(bbs_pkg::CH_CLOSE,  1'b0, 1'b0);
        queue_beat(bbs_pkg::CH_CLOSE,  1'b0, 1'b0);
        queue_beat(8'h00,              1'b0, 1'b0);
        queue_beat(8'hFF,              1'b1, 1'b1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (chars_to_send.size() != 0) @(posedge aclk);

        // random fragments across the idle phases, twice round
        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin
                    src_idle_pct  <= 0;
                    dst_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct  <= 86;
                    dst_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct  <= 0;
                    dst_stall_pct <= 86;
                end
                default: begin
                    src_idle_pct  <= 14;
                    dst_stall_pct <= 14;
                end
            endcase
            while (chars_to_send.size() < SEGMENT_BEATS) queue_fragment();
            while (chars_to_send.size() != 0) @(posedge aclk);
        end

        while (chars_to_send.size() != 0 || s_tvalid || scan_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_brace_balance_scanner: clean");
        end else begin
            $display("tb_brace_balance_scanner: errors");
        end
        $finish;
    end

endmodule
